@@ hdl/power_window_controller_assert.svh @@
// Assertion macros shared by the power window controller modules.
`ifndef POWER_WINDOW_CONTROLLER_ASSERT_SVH
`define POWER_WINDOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("pwc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("pwc: next-cycle check failed");

`endif

@@ hdl/pwc_pkg.sv @@
// Package: types, codes and constants of the power window controller.
`default_nettype none
package pwc_pkg;

    localparam int MODE_W    = 3;
    localparam int DRIVE_W   = 2;
    localparam int CNT_W     = 24;
    localparam int CFG_IDX_W = 8;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MUP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MDOWN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AUP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADOWN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REV   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PAUSE = 3'd6;

    // Motor drive codes
    localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_UP   = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS   = 8'd1;

    localparam logic [CNT_W-1:0] REVERSE_TICKS_RST = 24'd4000000;
    localparam logic [CNT_W-1:0] PAUSE_TICKS_RST   = 24'd2000000;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Classified tick handed from front to back
    typedef struct packed {
        logic              cmd_valid;
        logic [MODE_W-1:0] cmd_mode;
        logic              cmd_pas;
        logic              drv_up;
        logic              drv_down;
        logic              pas_up;
        logic              pas_down;
        logic              top_limit;
        logic              bottom_limit;
        logic              obstacle;
    } pwc_item_t;

    // Button position within one owner's group to command mode
    function automatic logic [MODE_W-1:0] cmd_mode_of(input logic [1:0] btn);
        logic [MODE_W-1:0] m;
        case (btn)
            2'd0:    m = MODE_MUP;
            2'd1:    m = MODE_MDOWN;
            2'd2:    m = MODE_AUP;
            default: m = MODE_ADOWN;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pwc_ifs.sv @@
// Handshake interfaces of the power window controller channels.
`default_nettype none

interface pwc_in_if;
    logic valid;
    logic ready;
    logic drv_up;
    logic drv_down;
    logic drv_auto_up;
    logic drv_auto_down;
    logic pas_up;
    logic pas_down;
    logic pas_auto_up;
    logic pas_auto_down;
    logic top_limit;
    logic bottom_limit;
    logic obstacle;

    modport source (
        output valid, drv_up, drv_down, drv_auto_up, drv_auto_down,
               pas_up, pas_down, pas_auto_up, pas_auto_down,
               top_limit, bottom_limit, obstacle,
        input  ready
    );
    modport sink (
        input  valid, drv_up, drv_down, drv_auto_up, drv_auto_down,
               pas_up, pas_down, pas_auto_up, pas_auto_down,
               top_limit, bottom_limit, obstacle,
        output ready
    );
endinterface

interface pwc_out_if;
    logic                         valid;
    logic                         ready;
    logic [pwc_pkg::DRIVE_W-1:0]  motor_drive;
    logic [pwc_pkg::MODE_W-1:0]   mode_now;
    logic                         obstacle_hit;

    modport source (output valid, motor_drive, mode_now, obstacle_hit, input ready);
    modport sink   (input  valid, motor_drive, mode_now, obstacle_hit, output ready);
endinterface

interface pwc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pwc_pkg::CFG_IDX_W-1:0] idx;
    logic [pwc_pkg::CNT_W-1:0]     data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input  valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ hdl/pwc_front.sv @@
// Front end: accepts pin words and picks the prioritized command.
`default_nettype none
module pwc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    pwc_in_if.sink                 pins,
    output pwc_pkg::pwc_item_t     item,
    output logic                   item_valid,
    input  wire logic              item_ready
);

    logic               vld_reg;
    pwc_pkg::pwc_item_t item_reg;
    pwc_pkg::pwc_item_t item_next;
    logic [7:0]         btn;
    logic               take;

    assign pins.ready = !vld_reg || item_ready;
    assign take       = pins.valid && pins.ready;

    assign btn = {pins.pas_auto_down, pins.pas_auto_up, pins.pas_down, pins.pas_up,
                  pins.drv_auto_down, pins.drv_auto_up, pins.drv_down, pins.drv_up};

    // Fixed priority: lowest button position wins
    always_comb
    begin
        item_next           = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (btn[i])
            begin
                item_next.cmd_valid = 1'b1;
                item_next.cmd_mode  = pwc_pkg::cmd_mode_of(2'(i));
                item_next.cmd_pas   = (i >= 4);
            end
        end
        item_next.drv_up       = pins.drv_up;
        item_next.drv_down     = pins.drv_down;
        item_next.pas_up       = pins.pas_up;
        item_next.pas_down     = pins.pas_down;
        item_next.top_limit    = pins.top_limit;
        item_next.bottom_limit = pins.bottom_limit;
        item_next.obstacle     = pins.obstacle;
    end

    // Holding register toward the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (pins.ready)
        begin
            vld_reg <= pins.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = vld_reg;

endmodule
`default_nettype wire

@@ hdl/pwc_fifo.sv @@
// Short word queue between the front end and the mode engine.
`default_nettype none
`include "power_window_controller_assert.svh"
module pwc_fifo #(
    parameter int DEPTH = pwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pwc_pkg::pwc_item_t push_item,
    output logic                    push_ready,
    input  wire logic               pop,
    output pwc_pkg::pwc_item_t      head_item,
    output logic                    head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pwc_pkg::pwc_item_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;
    assign head_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers wrap at the depth, which need not be a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `PWC_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, count_reg != '0)

endmodule
`default_nettype wire

@@ hdl/pwc_back.sv @@
// Mode engine: window state machine, reversal timing and result register.
`default_nettype none
`include "power_window_controller_assert.svh"
module pwc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire pwc_pkg::pwc_item_t q_item,
    output logic                    q_pop,
    pwc_cfg_if.sink                 cfg,
    pwc_out_if.source               result
);

    localparam logic [pwc_pkg::CNT_W-1:0] CNT_ONE = pwc_pkg::CNT_W'(1);

    logic [pwc_pkg::CNT_W-1:0]   reverse_ticks_reg;
    logic [pwc_pkg::CNT_W-1:0]   pause_ticks_reg;

    logic [pwc_pkg::MODE_W-1:0]  mode_reg;
    logic [pwc_pkg::MODE_W-1:0]  mode_next;
    logic                        pas_reg;
    logic                        pas_next;
    logic [pwc_pkg::CNT_W-1:0]   delay_reg;
    logic [pwc_pkg::CNT_W-1:0]   delay_next;

    logic                        out_vld_reg;
    logic [pwc_pkg::DRIVE_W-1:0] drive_reg;
    logic [pwc_pkg::DRIVE_W-1:0] drive_next;
    logic [pwc_pkg::MODE_W-1:0]  mode_out_reg;
    logic [pwc_pkg::MODE_W-1:0]  mode_out_next;
    logic                        hit_reg;
    logic                        hit_next;

    logic [pwc_pkg::MODE_W-1:0]  run_mode;
    logic                        held;
    logic                        rev_active;
    logic [pwc_pkg::CNT_W-1:0]   rev_dc;

    // Config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_ticks_reg <= pwc_pkg::REVERSE_TICKS_RST;
            pause_ticks_reg   <= pwc_pkg::PAUSE_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.idx)
                pwc_pkg::REG_REVERSE_TICKS: reverse_ticks_reg <= cfg.data;
                pwc_pkg::REG_PAUSE_TICKS:   pause_ticks_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pop whenever the result register is free or being drained
    assign q_pop = q_valid && (!out_vld_reg || result.ready);

    // Next state and result for the head word
    always_comb
    begin
        pas_next      = pas_reg;
        run_mode      = mode_reg;
        if (mode_reg == pwc_pkg::MODE_IDLE && q_item.cmd_valid)
        begin
            run_mode = q_item.cmd_mode;
            pas_next = q_item.cmd_pas;
        end
        held          = 1'b0;
        hit_next      = 1'b0;
        rev_active    = 1'b0;
        mode_next     = pwc_pkg::MODE_IDLE;
        delay_next    = '0;
        drive_next    = pwc_pkg::DRIVE_OFF;
        mode_out_next = pwc_pkg::MODE_IDLE;

        unique case (run_mode)
            pwc_pkg::MODE_MUP:
            begin
                held = pas_next ? q_item.pas_up : q_item.drv_up;
                if (q_item.obstacle)
                begin
                    hit_next = 1'b1;
                end
                else if (held && !q_item.top_limit)
                begin
                    mode_next     = pwc_pkg::MODE_MUP;
                    delay_next    = delay_reg;
                    drive_next    = pwc_pkg::DRIVE_UP;
                    mode_out_next = pwc_pkg::MODE_MUP;
                end
            end
            pwc_pkg::MODE_MDOWN:
            begin
                held = pas_next ? q_item.pas_down : q_item.drv_down;
                if (held && !q_item.bottom_limit)
                begin
                    mode_next     = pwc_pkg::MODE_MDOWN;
                    delay_next    = delay_reg;
                    drive_next    = pwc_pkg::DRIVE_DOWN;
                    mode_out_next = pwc_pkg::MODE_MDOWN;
                end
            end
            pwc_pkg::MODE_AUP:
            begin
                if (q_item.obstacle)
                begin
                    hit_next = 1'b1;
                end
                else if (!q_item.top_limit)
                begin
                    mode_next     = pwc_pkg::MODE_AUP;
                    delay_next    = delay_reg;
                    drive_next    = pwc_pkg::DRIVE_UP;
                    mode_out_next = pwc_pkg::MODE_AUP;
                end
            end
            pwc_pkg::MODE_ADOWN:
            begin
                if (!q_item.bottom_limit)
                begin
                    mode_next     = pwc_pkg::MODE_ADOWN;
                    delay_next    = delay_reg;
                    drive_next    = pwc_pkg::DRIVE_DOWN;
                    mode_out_next = pwc_pkg::MODE_ADOWN;
                end
            end
            pwc_pkg::MODE_REV:
            begin
                rev_active = 1'b1;
            end
            pwc_pkg::MODE_PAUSE:
            begin
                mode_out_next = pwc_pkg::MODE_PAUSE;
                if (delay_reg > CNT_ONE)
                begin
                    mode_next  = pwc_pkg::MODE_PAUSE;
                    delay_next = delay_reg - CNT_ONE;
                end
            end
            default: ;
        endcase

        // Reversal tick, either continuing or started by an obstacle this tick
        rev_dc = hit_next ? reverse_ticks_reg : delay_reg;
        if (hit_next || rev_active)
        begin
            drive_next    = pwc_pkg::DRIVE_DOWN;
            mode_out_next = pwc_pkg::MODE_REV;
            if (rev_dc > CNT_ONE)
            begin
                mode_next  = pwc_pkg::MODE_REV;
                delay_next = rev_dc - CNT_ONE;
            end
            else if (pause_ticks_reg != '0)
            begin
                mode_next  = pwc_pkg::MODE_PAUSE;
                delay_next = pause_ticks_reg;
            end
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pwc_pkg::MODE_IDLE;
            pas_reg     <= 1'b0;
            delay_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg  <= mode_next;
                pas_reg   <= pas_next;
                delay_reg <= delay_next;
            end
            if (q_pop)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            drive_reg    <= drive_next;
            mode_out_reg <= mode_out_next;
            hit_reg      <= hit_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.motor_drive  = drive_reg;
    assign result.mode_now     = mode_out_reg;
    assign result.obstacle_hit = hit_reg;

    `PWC_ASSERT_NOW(a_hit_drives_down, clk, rst_n, out_vld_reg && hit_reg,
        drive_reg == pwc_pkg::DRIVE_DOWN && mode_out_reg == pwc_pkg::MODE_REV)
    `PWC_ASSERT_NEXT(a_pause_ends_idle, clk, rst_n,
        q_pop && mode_reg == pwc_pkg::MODE_PAUSE && delay_reg <= CNT_ONE,
        mode_reg == pwc_pkg::MODE_IDLE)
    `PWC_ASSERT_NEXT(a_rev_counts_down, clk, rst_n,
        q_pop && mode_reg == pwc_pkg::MODE_REV && delay_reg > CNT_ONE,
        mode_reg == pwc_pkg::MODE_REV && delay_reg == $past(delay_reg) - CNT_ONE)

endmodule
`default_nettype wire

@@ hdl/power_window_controller.sv @@
// Top level of the power window controller with anti-pinch reversal.
// One pin word per clock goes in and one result word per clock comes out, sustained
// while the output side is ready; each result passes the front register, the queue
// and the result register, and is held back while the output side stalls. The rate
// is set by the mode update in the back-end state machine, whose reversal and
// pause counter steps once per word. The queue of QUEUE_DEPTH words lets the
// front keep taking words for a short while when the output stalls. Configuration
// writes are taken at any time but must only be issued while the block is idle.
`default_nettype none
module power_window_controller #(
    parameter int QUEUE_DEPTH = pwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pwc_in_if.sink      pins,
    pwc_out_if.source   result,
    pwc_cfg_if.sink     cfg
);

    pwc_pkg::pwc_item_t front_item;
    logic               front_valid;
    logic               q_ready;
    pwc_pkg::pwc_item_t head_item;
    logic               head_valid;
    logic               q_pop;

    pwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pins       (pins),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (q_ready)
    );

    pwc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    pwc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_item  (head_item),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .result  (result)
    );

endmodule
`default_nettype wire
